// ===== hdl/aes128_pkg.sv =====
// Package for the AES-128 block encryption core.
// Holds widths, operation codes, the S-box table and the round functions.
// No dependencies.
`default_nettype none

package aes128_pkg;

  localparam int HALF_W     = 64;
  localparam int BLOCK_W    = 2 * HALF_W;
  localparam int KEY_WORDS  = 22;
  localparam int KEY_IDX_W  = 5;
  localparam int NUM_ROUNDS = 10;

  localparam logic [7:0] MIX_REDUCE = 8'h1b;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ENCRYPT = 1'b1
  } op_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [3:0] SHIFT_SRC [16] = '{
    4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
    4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11
  };

  function automatic logic [7:0] xtime(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? MIX_REDUCE : 8'h00);
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_shift(logic [BLOCK_W-1:0] s);
    logic [7:0]         t [16];
    logic [BLOCK_W-1:0] o;
    for (int i = 0; i < 16; i++) begin
      t[i] = SBOX[s[BLOCK_W-1-8*i -: 8]];
    end
    for (int i = 0; i < 16; i++) begin
      o[BLOCK_W-1-8*i -: 8] = t[SHIFT_SRC[i]];
    end
    return o;
  endfunction

  function automatic logic [BLOCK_W-1:0] mix_columns(logic [BLOCK_W-1:0] s);
    logic [7:0]         a [4];
    logic [BLOCK_W-1:0] o;
    logic [1:0]         r1;
    logic [1:0]         r2;
    logic [1:0]         r3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r] = s[BLOCK_W-1-8*(4*c+r) -: 8];
      end
      for (int r = 0; r < 4; r++) begin
        r1 = 2'(r + 1);
        r2 = 2'(r + 2);
        r3 = 2'(r + 3);
        o[BLOCK_W-1-8*(4*c+r) -: 8] = xtime(a[r]) ^ xtime(a[r1]) ^ a[r1] ^ a[r2] ^ a[r3];
      end
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/aes128_if.sv =====
// Valid/ready channel interfaces for the AES-128 core: request and result.
// Depends on aes128_pkg for the field widths.
`default_nettype none

interface aes128_in_if import aes128_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [KEY_IDX_W-1:0] key_word_index;
  logic [HALF_W-1:0]    key_word;
  logic [HALF_W-1:0]    block_high;
  logic [HALF_W-1:0]    block_low;

  modport source (output valid, operation, key_word_index, key_word, block_high, block_low,
                  input ready);
  modport sink   (input valid, operation, key_word_index, key_word, block_high, block_low,
                  output ready);
endinterface

interface aes128_out_if import aes128_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] cipher_high;
  logic [HALF_W-1:0] cipher_low;

  modport source (output valid, cipher_high, cipher_low, input ready);
  modport sink   (input valid, cipher_high, cipher_low, output ready);
endinterface

`default_nettype wire

// ===== hdl/aes128_key_store.sv =====
// Round key store: 22 words of 64 bits, written one word per load transfer.
// Depends on aes128_pkg.
`default_nettype none

module aes128_key_store import aes128_pkg::*; (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [KEY_IDX_W-1:0] wr_idx,
  input  logic [HALF_W-1:0]    wr_data,
  output logic [HALF_W-1:0]    words [KEY_WORDS]
);

  logic [HALF_W-1:0] words_r [KEY_WORDS];

  // Drop writes to slots beyond the last word.
  always_ff @(posedge clk) begin
    for (int j = 0; j < KEY_WORDS; j++) begin
      if (wr_en && wr_idx == KEY_IDX_W'(j)) begin
        words_r[j] <= wr_data;
      end
    end
  end

  assign words = words_r;

endmodule

`default_nettype wire

// ===== hdl/aes128_round_cell.sv =====
// One AES round cell: SubBytes, ShiftRows, optional MixColumns, key XOR.
// Holds its own state and valid bit. Depends on aes128_pkg.
`default_nettype none

module aes128_round_cell import aes128_pkg::*; #(
  parameter bit MIX_EN = 1'b1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_in,
  input  logic [BLOCK_W-1:0] state_in,
  input  logic [BLOCK_W-1:0] round_key,
  output logic               valid_out,
  output logic [BLOCK_W-1:0] state_out
);

  logic               valid_r;
  logic [BLOCK_W-1:0] state_r;
  logic [BLOCK_W-1:0] shifted;
  logic [BLOCK_W-1:0] state_nxt;

  always_comb begin
    shifted = sub_shift(state_in);
    if (MIX_EN) begin
      state_nxt = mix_columns(shifted) ^ round_key;
    end else begin
      state_nxt = shifted ^ round_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= state_nxt;
    end
  end

  assign valid_out = valid_r;
  assign state_out = state_r;

endmodule

`default_nettype wire

// ===== hdl/aes128_block_encrypt_core.sv =====
// AES-128 block encryption core: key store, initial key XOR and ten round cells.
// Depends on aes128_pkg, aes128_if, aes128_key_store and aes128_round_cell.
//
// Usage:
//   in_ch carries two kinds of transfer. A load (operation 0) writes key_word
//   into round key slot key_word_index; slots 22 to 31 are dropped. An encrypt
//   (operation 1) carries a plaintext block as block_high / block_low.
//   out_ch carries one ciphertext per encrypt transfer, in order.
//   All eleven round keys must be loaded before the first encrypt.
// Pipeline and throughput:
//   The initial key XOR is registered at the input transfer, then each of the
//   ten round cells adds one register; out_ch shows the tenth cell's register.
//   Encrypts are taken one per cycle unless out_ch stalls. A load waits until
//   round cells one to nine and the key XOR stage are empty, so blocks in
//   flight keep their keys.
// Reset:
//   rst_n (synchronous, active low) empties the pipeline; stored keys persist
//   undefined until loaded.
// Stall:
//   While out_ch holds a result that is not taken, the whole chain holds and
//   in_ch.ready is low.
`default_nettype none

module aes128_block_encrypt_core import aes128_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  aes128_in_if.sink     in_ch,
  aes128_out_if.source  out_ch
);

  logic                 advance;
  logic                 pipe_busy;
  logic                 is_enc;
  logic                 accept;
  logic [HALF_W-1:0]    key_words [KEY_WORDS];
  logic [NUM_ROUNDS:0]  stage_valid;
  logic [BLOCK_W-1:0]   stage_state [NUM_ROUNDS+1];
  logic                 v0_r;
  logic [BLOCK_W-1:0]   st0_r;

  assign is_enc    = (in_ch.operation == OP_ENCRYPT);
  assign advance   = !stage_valid[NUM_ROUNDS] || out_ch.ready;
  assign pipe_busy = |stage_valid[NUM_ROUNDS-1:0];
  assign in_ch.ready = advance && (is_enc || !pipe_busy);
  assign accept    = in_ch.valid && in_ch.ready;

  aes128_key_store u_keys (
    .clk     (clk),
    .wr_en   (accept && !is_enc),
    .wr_idx  (in_ch.key_word_index),
    .wr_data (in_ch.key_word),
    .words   (key_words)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (advance) begin
      v0_r <= accept && is_enc;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st0_r <= {in_ch.block_high, in_ch.block_low} ^ {key_words[0], key_words[1]};
    end
  end

  assign stage_valid[0] = v0_r;
  assign stage_state[0] = st0_r;

  for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
    aes128_round_cell #(
      .MIX_EN (r != NUM_ROUNDS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (advance),
      .valid_in  (stage_valid[r-1]),
      .state_in  (stage_state[r-1]),
      .round_key ({key_words[2*r], key_words[2*r+1]}),
      .valid_out (stage_valid[r]),
      .state_out (stage_state[r])
    );
  end

  assign out_ch.valid       = stage_valid[NUM_ROUNDS];
  assign out_ch.cipher_high = stage_state[NUM_ROUNDS][BLOCK_W-1:HALF_W];
  assign out_ch.cipher_low  = stage_state[NUM_ROUNDS][HALF_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/aes128_checker.sv =====
// Port-level checker for the AES-128 core, with its bind to the top level.
// Depends on aes128_pkg and the top level's channel interfaces.
`default_nettype none

module aes128_checker import aes128_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_operation,
  input logic              out_valid,
  input logic              out_ready,
  input logic [HALF_W-1:0] out_cipher_high,
  input logic [HALF_W-1:0] out_cipher_low
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cipher_high) && $stable(out_cipher_low))
    else $error("stalled result changed or dropped");

  // A stalled result stops every input transfer.
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // An empty output stage never refuses an encrypt.
  a_enc_flows: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && in_operation == OP_ENCRYPT |-> in_ready)
    else $error("encrypt refused with empty output");

  // A load transfer never produces a result at the next edge from an empty chain.
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid && in_ready && in_operation == OP_LOAD |=> !out_valid)
    else $error("result appeared after a load into an idle chain");

endmodule

bind aes128_block_encrypt_core aes128_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_operation    (in_ch.operation),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_cipher_high (out_ch.cipher_high),
  .out_cipher_low  (out_ch.cipher_low)
);

`default_nettype wire
